FILE: hw/rtl/tgs_pkg.sv
`default_nettype none
// ============================================================================
// tgs_pkg
// Shared types and constants of the text grid with scrollback.
// ============================================================================
package tgs_pkg;

    localparam int KIND_W     = 4;
    localparam int COL_W      = 7;
    localparam int ROW_W      = 6;
    localparam int CELL_W     = 32;
    localparam int OFF_W      = 9;
    localparam int CNT_OUT_W  = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 7;
    localparam int HLIM_W     = 9;

    localparam int COLS_RESET = 80;
    localparam int ROWS_RESET = 24;
    localparam int HLIM_RESET = 256;

    localparam int Q_DEPTH = 2;
    localparam int QPW     = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    typedef enum logic [KIND_W-1:0] {
        K_WRITE       = 4'd0,
        K_READ        = 4'd1,
        K_READ_VIS    = 4'd2,
        K_SCROLL_UP   = 4'd3,
        K_SCROLL_DOWN = 4'd4,
        K_SET_FLAG    = 4'd5,
        K_READ_FLAG   = 4'd6,
        K_SET_OFFSET  = 4'd7,
        K_CLEAR       = 4'd8
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLS   = 2'd0,
        CFG_ROWS   = 2'd1,
        CFG_HLIMIT = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACCESS,
        S_READ_DATA,
        S_HIST_COPY,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_CLEAR_ROW,
        S_CLEAR_ALL,
        S_DONE
    } t_state;

    // classified request as queued between front and back
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  cx;
        logic [ROW_W-1:0]  cy;
        logic [ROW_W-1:0]  row;
        logic              row_ok;
        logic [CELL_W-1:0] cval;
        logic              wrap;
        logic [OFF_W-1:0]  offset;
    } t_cmd;

endpackage
`default_nettype wire

FILE: hw/rtl/tgs_ifs.sv
`default_nettype none
// ============================================================================
// tgs_ifs
// Request, result and register write channels.
// ============================================================================
interface tgs_item_if;
    logic                          valid;
    logic                          ready;
    logic [tgs_pkg::KIND_W-1:0]    kind;
    logic [tgs_pkg::COL_W-1:0]     col;
    logic [tgs_pkg::ROW_W-1:0]     row;
    logic [tgs_pkg::CELL_W-1:0]    cell_in;
    logic                          wrap_in;
    logic [tgs_pkg::OFF_W-1:0]     offset_in;

    modport source (output valid, kind, col, row, cell_in, wrap_in, offset_in, input ready);
    modport sink   (input valid, kind, col, row, cell_in, wrap_in, offset_in, output ready);
endinterface

interface tgs_result_if;
    logic                          valid;
    logic                          ready;
    logic [tgs_pkg::CELL_W-1:0]    cell_out;
    logic                          wrap_out;
    logic [tgs_pkg::OFF_W-1:0]     view_offset_out;
    logic [tgs_pkg::CNT_OUT_W-1:0] history_count_out;

    modport source (output valid, cell_out, wrap_out, view_offset_out, history_count_out,
                    input ready);
    modport sink   (input valid, cell_out, wrap_out, view_offset_out, history_count_out,
                    output ready);
endinterface

interface tgs_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tgs_pkg::CFG_IDX_W-1:0] index;
    logic [tgs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tgs_front.sv
`default_nettype none
// ============================================================================
// tgs_front
// Accepts requests, clamps coordinates and queues them for the back end.
// ============================================================================
module tgs_front #(
    parameter int MAX_COLS = 128,
    parameter int MAX_ROWS = 64
) (
    tgs_item_if.sink                        i_item,
    input  wire [$clog2(MAX_COLS+1)-1:0]    i_cols,
    input  wire [$clog2(MAX_ROWS+1)-1:0]    i_rows,
    input  wire                             i_hold,
    input  wire                             i_q_full,
    output logic                            o_push,
    output tgs_pkg::t_cmd                   o_cmd
);
    import tgs_pkg::*;

    always_comb begin
        i_item.ready = !i_q_full && !i_hold;
        o_push       = i_item.valid && i_item.ready;

        o_cmd.kind   = i_item.kind;
        o_cmd.cval   = i_item.cell_in;
        o_cmd.wrap   = i_item.wrap_in;
        o_cmd.offset = i_item.offset_in;
        o_cmd.row    = i_item.row;
        o_cmd.row_ok = 32'(i_item.row) < 32'(i_rows);
        if (32'(i_item.col) >= 32'(i_cols)) begin
            o_cmd.cx = COL_W'(32'(i_cols) - 32'd1);
        end else begin
            o_cmd.cx = i_item.col;
        end
        if (32'(i_item.row) >= 32'(i_rows)) begin
            o_cmd.cy = ROW_W'(32'(i_rows) - 32'd1);
        end else begin
            o_cmd.cy = i_item.row;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tgs_queue.sv
`default_nettype none
// ============================================================================
// tgs_queue
// Short request queue between front and back.
// ============================================================================
module tgs_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  tgs_pkg::t_cmd   i_data,
    input  wire             i_pop,
    output tgs_pkg::t_cmd   o_data,
    output logic            o_full,
    output logic            o_empty
);
    import tgs_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [QPW-1:0]  r_wp;
    logic [QPW-1:0]  r_rp;
    logic [QCW-1:0]  r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_full  = (32'(r_cnt) == Q_DEPTH);
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (32'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (32'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tgs_back.sv
`default_nettype none
// ============================================================================
// tgs_back
// Executes queued requests on the screen and history memories.
// ============================================================================
module tgs_back #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_HISTORY = 256,
    parameter int CELL_BITS   = 32
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire [$clog2(MAX_COLS+1)-1:0]    i_cols,
    input  wire [$clog2(MAX_ROWS+1)-1:0]    i_rows,
    input  wire [tgs_pkg::HLIM_W-1:0]       i_hlimit,
    input  tgs_pkg::t_cmd                   i_cmd,
    input  wire                             i_q_empty,
    output logic                            o_pop,
    output logic                            o_hold,
    tgs_result_if.source                    o_result
);
    import tgs_pkg::*;

    localparam int SD   = MAX_COLS * MAX_ROWS;
    localparam int HD   = MAX_HISTORY * MAX_COLS;
    localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int HAW  = (HD > 1) ? $clog2(HD) : 1;
    localparam int CNTW = $clog2(SD + 1);
    localparam int HCW  = $clog2(MAX_HISTORY + 1);
    localparam int HSW  = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;

    logic [CELL_BITS-1:0] r_screen [SD];
    logic [CELL_BITS-1:0] r_hist   [HD];
    logic [CELL_BITS-1:0] r_srd;
    logic [CELL_BITS-1:0] r_hrd;

    t_state               r_state,  n_state;
    t_cmd                 r_cmd,    n_cmd;
    logic [ROW_W-1:0]     r_ry,     n_ry;
    logic [HSW-1:0]       r_slot,   n_slot;
    logic                 r_vhist,  n_vhist;
    logic [CNTW-1:0]      r_i,      n_i;
    logic [CNTW-1:0]      r_lim,    n_lim;
    logic [CNTW-1:0]      r_end,    n_end;
    logic [HAW-1:0]       r_hbase,  n_hbase;
    logic                 r_pv,     n_pv;
    logic [SAW-1:0]       r_psa,    n_psa;
    logic [HAW-1:0]       r_pha,    n_pha;
    logic [MAX_ROWS-1:0]  r_flags,  n_flags;
    logic [HCW-1:0]       r_cnt,    n_cnt;
    logic [HSW-1:0]       r_old,    n_old;
    logic [HCW-1:0]       r_vo,     n_vo;
    logic                 r_init,   n_init;

    logic                 r_ovalid;
    logic [CELL_W-1:0]    r_ocell;
    logic                 r_owrap;
    logic [OFF_W-1:0]     r_ovo;
    logic [CNT_OUT_W-1:0] r_ocnt;

    logic                 emit;
    logic [CELL_W-1:0]    e_cell;
    logic                 e_wrap;
    logic                 out_free;
    logic                 flag_rd;

    logic                 s_we, s_re, h_we, h_re;
    logic [SAW-1:0]       s_waddr, s_raddr, scr_addr;
    logic [HAW-1:0]       h_waddr, h_raddr, hist_addr;
    logic [CELL_BITS-1:0] s_wdata, h_wdata;

    assign o_result.valid             = r_ovalid;
    assign o_result.cell_out          = r_ocell;
    assign o_result.wrap_out          = r_owrap;
    assign o_result.view_offset_out   = r_ovo;
    assign o_result.history_count_out = r_ocnt;
    assign o_hold                     = r_init;

    assign out_free  = !r_ovalid || o_result.ready;
    assign scr_addr  = SAW'(32'(r_ry) * 32'(i_cols) + 32'(r_cmd.cx));
    assign hist_addr = HAW'(32'(r_slot) * 32'(MAX_COLS) + 32'(r_cmd.cx));

    always_comb begin
        flag_rd = 1'b0;
        for (int y = 0; y < MAX_ROWS; y++) begin
            if (32'(y) == 32'(r_cmd.row)) begin
                flag_rd = r_flags[y];
            end
        end
    end

    always_comb begin
        logic [31:0] t_d, t_idx, t_sum, t_y, t_slot, t_old, t_cnt, t_vo;
        n_state = r_state;
        n_cmd   = r_cmd;
        n_ry    = r_ry;
        n_slot  = r_slot;
        n_vhist = r_vhist;
        n_i     = r_i;
        n_lim   = r_lim;
        n_end   = r_end;
        n_hbase = r_hbase;
        n_pv    = 1'b0;
        n_psa   = r_psa;
        n_pha   = r_pha;
        n_flags = r_flags;
        n_cnt   = r_cnt;
        n_old   = r_old;
        n_vo    = r_vo;
        n_init  = r_init;
        emit    = 1'b0;
        e_cell  = '0;
        e_wrap  = 1'b0;
        o_pop   = 1'b0;
        s_we    = 1'b0;
        s_waddr = r_psa;
        s_wdata = r_srd;
        s_re    = 1'b0;
        s_raddr = scr_addr;
        h_we    = 1'b0;
        h_waddr = r_pha;
        h_wdata = r_srd;
        h_re    = 1'b0;
        h_raddr = hist_addr;
        t_d     = '0;
        t_idx   = '0;
        t_sum   = '0;
        t_y     = '0;
        t_slot  = '0;
        t_old   = '0;
        t_cnt   = '0;
        t_vo    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_ry    = i_cmd.cy;
                    n_vhist = 1'b0;
                    n_state = S_ACCESS;
                    if (i_cmd.kind == K_READ_VIS) begin
                        if (32'(i_cmd.row) >= 32'(r_vo)) begin
                            t_y = 32'(i_cmd.row) - 32'(r_vo);
                            if (t_y >= 32'(i_rows)) begin
                                t_y = 32'(i_rows) - 32'd1;
                            end
                            n_ry = ROW_W'(t_y);
                        end else begin
                            // view row lies in history
                            t_d   = 32'(r_vo) - 32'(i_cmd.row);
                            t_idx = (32'(r_cnt) > t_d) ? 32'(r_cnt) - t_d : 32'd0;
                            t_sum = 32'(r_old) + t_idx;
                            if (t_sum >= MAX_HISTORY) begin
                                t_sum = t_sum - MAX_HISTORY;
                            end
                            n_slot  = HSW'(t_sum);
                            n_vhist = 1'b1;
                        end
                    end
                end
            end

            S_ACCESS: begin
                case (r_cmd.kind)
                    K_WRITE: begin
                        if (out_free) begin
                            s_we    = 1'b1;
                            s_waddr = scr_addr;
                            s_wdata = CELL_BITS'(r_cmd.cval);
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_READ: begin
                        s_re    = 1'b1;
                        n_state = S_READ_DATA;
                    end
                    K_READ_VIS: begin
                        if (!r_vhist) begin
                            s_re    = 1'b1;
                            n_state = S_READ_DATA;
                        end else if (r_cnt != '0) begin
                            h_re    = 1'b1;
                            n_state = S_READ_DATA;
                        end else if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_SCROLL_UP: begin
                        if (32'(r_cnt) >= MAX_HISTORY) begin
                            t_slot = 32'(r_old);
                            t_old  = (32'(r_old) + 32'd1 == MAX_HISTORY) ? 32'd0
                                                                         : 32'(r_old) + 32'd1;
                            t_cnt  = 32'(r_cnt);
                        end else begin
                            t_sum  = 32'(r_old) + 32'(r_cnt);
                            t_slot = (t_sum >= MAX_HISTORY) ? t_sum - MAX_HISTORY : t_sum;
                            t_old  = 32'(r_old);
                            t_cnt  = 32'(r_cnt) + 32'd1;
                        end
                        if (t_cnt > 32'(i_hlimit)) begin
                            t_old = (t_old + 32'd1 == MAX_HISTORY) ? 32'd0 : t_old + 32'd1;
                            t_cnt = t_cnt - 32'd1;
                        end
                        t_vo = 32'd0;
                        if (r_vo != '0) begin
                            t_vo = (32'(r_vo) + 32'd1 > t_cnt) ? t_cnt : 32'(r_vo) + 32'd1;
                        end
                        n_cnt   = HCW'(t_cnt);
                        n_old   = HSW'(t_old);
                        n_vo    = HCW'(t_vo);
                        n_hbase = HAW'(t_slot * 32'(MAX_COLS));
                        n_lim   = CNTW'((32'(i_rows) - 32'd1) * 32'(i_cols));
                        n_i     = '0;
                        for (int y = 0; y < MAX_ROWS - 1; y++) begin
                            if (32'(y) + 32'd1 < 32'(i_rows)) begin
                                n_flags[y] = r_flags[y+1];
                            end
                        end
                        for (int y = 0; y < MAX_ROWS; y++) begin
                            if (32'(y) + 32'd1 == 32'(i_rows)) begin
                                n_flags[y] = 1'b0;
                            end
                        end
                        n_state = S_HIST_COPY;
                    end
                    K_SCROLL_DOWN: begin
                        for (int y = 1; y < MAX_ROWS; y++) begin
                            if (32'(y) < 32'(i_rows)) begin
                                n_flags[y] = r_flags[y-1];
                            end
                        end
                        n_flags[0] = 1'b0;
                        n_i        = CNTW'(32'(i_rows) * 32'(i_cols));
                        n_state    = S_SHIFT_DOWN;
                    end
                    K_SET_FLAG: begin
                        if (out_free) begin
                            if (r_cmd.row_ok) begin
                                for (int y = 0; y < MAX_ROWS; y++) begin
                                    if (32'(y) == 32'(r_cmd.row)) begin
                                        n_flags[y] = r_cmd.wrap;
                                    end
                                end
                            end
                            e_wrap  = r_cmd.row_ok && r_cmd.wrap;
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_READ_FLAG: begin
                        if (out_free) begin
                            e_wrap  = r_cmd.row_ok && flag_rd;
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_SET_OFFSET: begin
                        if (out_free) begin
                            n_vo    = (32'(r_cmd.offset) > 32'(r_cnt)) ? r_cnt
                                                                       : HCW'(r_cmd.offset);
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                    K_CLEAR: begin
                        n_flags = '0;
                        n_cnt   = '0;
                        n_old   = '0;
                        n_vo    = '0;
                        n_i     = '0;
                        n_state = S_CLEAR_ALL;
                    end
                    default: begin
                        if (out_free) begin
                            emit    = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end

            S_READ_DATA: begin
                if (out_free) begin
                    e_cell  = r_vhist ? CELL_W'(r_hrd) : CELL_W'(r_srd);
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_HIST_COPY: begin
                h_we = r_pv;
                if (32'(r_i) < 32'(i_cols)) begin
                    s_re    = 1'b1;
                    s_raddr = SAW'(r_i);
                    n_pv    = 1'b1;
                    n_pha   = HAW'(32'(r_hbase) + 32'(r_i));
                    n_i     = r_i + 1'b1;
                end else begin
                    n_i     = '0;
                    n_state = S_SHIFT_UP;
                end
            end

            S_SHIFT_UP: begin
                s_we = r_pv;
                if (r_i < r_lim) begin
                    s_re    = 1'b1;
                    s_raddr = SAW'(32'(r_i) + 32'(i_cols));
                    n_pv    = 1'b1;
                    n_psa   = SAW'(r_i);
                    n_i     = r_i + 1'b1;
                end else begin
                    n_end   = CNTW'(32'(r_lim) + 32'(i_cols));
                    n_state = S_CLEAR_ROW;
                end
            end

            S_SHIFT_DOWN: begin
                s_we = r_pv;
                if (32'(r_i) > 32'(i_cols)) begin
                    s_re    = 1'b1;
                    s_raddr = SAW'(32'(r_i) - 32'd1 - 32'(i_cols));
                    n_pv    = 1'b1;
                    n_psa   = SAW'(32'(r_i) - 32'd1);
                    n_i     = r_i - 1'b1;
                end else begin
                    n_i     = '0;
                    n_end   = CNTW'(i_cols);
                    n_state = S_CLEAR_ROW;
                end
            end

            S_CLEAR_ROW: begin
                if (r_i < r_end) begin
                    s_we    = 1'b1;
                    s_waddr = SAW'(r_i);
                    s_wdata = '0;
                    n_i     = r_i + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_CLEAR_ALL: begin
                s_we    = 1'b1;
                s_waddr = SAW'(r_i);
                s_wdata = '0;
                if (32'(r_i) == SD - 1) begin
                    n_i     = '0;
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_DONE;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR_ALL;
            r_init   <= 1'b1;
            r_i      <= '0;
            r_pv     <= 1'b0;
            r_flags  <= '0;
            r_cnt    <= '0;
            r_old    <= '0;
            r_vo     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_init  <= n_init;
            r_i     <= n_i;
            r_pv    <= n_pv;
            r_flags <= n_flags;
            r_cnt   <= n_cnt;
            r_old   <= n_old;
            r_vo    <= n_vo;
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ry    <= n_ry;
        r_slot  <= n_slot;
        r_vhist <= n_vhist;
        r_lim   <= n_lim;
        r_end   <= n_end;
        r_hbase <= n_hbase;
        r_psa   <= n_psa;
        r_pha   <= n_pha;
        if (emit) begin
            r_ocell <= e_cell;
            r_owrap <= e_wrap;
            r_ovo   <= OFF_W'(n_vo);
            r_ocnt  <= CNT_OUT_W'(n_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_screen[s_waddr] <= s_wdata;
        end
        if (s_re) begin
            r_srd <= r_screen[s_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            r_hist[h_waddr] <= h_wdata;
        end
        if (h_re) begin
            r_hrd <= r_hist[h_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/text_grid_with_scrollback_unit.sv
`default_nettype none
// ============================================================================
// text_grid_with_scrollback_unit
// Character screen with per-row wrap flags and a scrollback history ring.
// ============================================================================
// Usage:
//   i_item   request channel (kind, col, row, cell_in, wrap_in, offset_in).
//   o_result one result per request, in request order.
//   i_cfg    register writes: 0 cols, 1 rows, 2 history limit; always ready.
//            Write only while no request is outstanding.
// A front stage clamps coordinates into a two-entry queue; the back end
// owns the screen and history memories and runs one request at a time.
// In the back end, scroll and clear requests move one cell per cycle,
// set by the single write port of the screen memory.
// After reset all MAX_COLS*MAX_ROWS cells of the screen memory are zeroed
// with i_item.ready low.
// The result sits in an output register; while the receiver stalls the
// queue still takes up to two more requests.
// ============================================================================
module text_grid_with_scrollback_unit #(
    parameter int MAX_COLS    = 128,
    parameter int MAX_ROWS    = 64,
    parameter int MAX_HISTORY = 256,
    parameter int CELL_BITS   = 32
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    tgs_item_if.sink        i_item,
    tgs_result_if.source    o_result,
    tgs_cfg_if.sink         i_cfg
);
    import tgs_pkg::*;

    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int RST_COLS = (COLS_RESET > MAX_COLS) ? MAX_COLS : COLS_RESET;
    localparam int RST_ROWS = (ROWS_RESET > MAX_ROWS) ? MAX_ROWS : ROWS_RESET;
    localparam int RST_HLIM = (HLIM_RESET > MAX_HISTORY) ? MAX_HISTORY : HLIM_RESET;

    logic [CW-1:0]     r_cols;
    logic [RCW-1:0]    r_rows;
    logic [HLIM_W-1:0] r_hlimit;
    logic [31:0]       cv_cols, cv_rows, cv_hlim;

    t_cmd front_cmd, q_cmd;
    logic push, pop, q_full, q_empty, hold;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        cv_cols = 32'(i_cfg.data[COLS_REG_W-1:0]);
        cv_rows = 32'(i_cfg.data[ROWS_REG_W-1:0]);
        cv_hlim = 32'(i_cfg.data[HLIM_W-1:0]);
        if (cv_cols == 32'd0) begin
            cv_cols = 32'd1;
        end else if (cv_cols > MAX_COLS) begin
            cv_cols = MAX_COLS;
        end
        if (cv_rows == 32'd0) begin
            cv_rows = 32'd1;
        end else if (cv_rows > MAX_ROWS) begin
            cv_rows = MAX_ROWS;
        end
        if (cv_hlim > MAX_HISTORY) begin
            cv_hlim = MAX_HISTORY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols   <= CW'(RST_COLS);
            r_rows   <= RCW'(RST_ROWS);
            r_hlimit <= HLIM_W'(RST_HLIM);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_COLS:   r_cols   <= CW'(cv_cols);
                CFG_ROWS:   r_rows   <= RCW'(cv_rows);
                CFG_HLIMIT: r_hlimit <= HLIM_W'(cv_hlim);
                default:    ;
            endcase
        end
    end

    tgs_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_item   (i_item),
        .i_cols   (r_cols),
        .i_rows   (r_rows),
        .i_hold   (hold),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    tgs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (q_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    tgs_back #(
        .MAX_COLS    (MAX_COLS),
        .MAX_ROWS    (MAX_ROWS),
        .MAX_HISTORY (MAX_HISTORY),
        .CELL_BITS   (CELL_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cols    (r_cols),
        .i_rows    (r_rows),
        .i_hlimit  (r_hlimit),
        .i_cmd     (q_cmd),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_hold    (hold),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

FILE: test/tgs_tb_pkg.sv
// ============================================================================
// tgs_tb_pkg
// Shared request and result types used by the screen buffer testbench.
// ============================================================================
package tgs_tb_pkg;
    import tgs_pkg::*;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] cval;
        logic              wrap;
        logic [OFF_W-1:0]  offset;
    } t_req;

    typedef struct {
        logic [CELL_W-1:0]    cval;
        logic                 wrap;
        logic [OFF_W-1:0]     view_offset;
        logic [CNT_OUT_W-1:0] hist_count;
    } t_rsp;
endpackage

FILE: test/text_grid_with_scrollback_unit_tb.sv
// ============================================================================
// text_grid_with_scrollback_unit_tb
// Drives cell, flag, scroll, offset and clear requests with random gaps and
// stalls, predicts every result from a behavioral copy of the screen and
// history, and compares each result field by field in request order.
// ============================================================================
module text_grid_with_scrollback_unit_tb;
    import tgs_pkg::*;
    import tgs_tb_pkg::*;

    localparam int NCOL = 128;
    localparam int NROW = 64;
    localparam int NHIST = 256;
    localparam int WATCHDOG = 200000;
    localparam int EXP_DEPTH = 16;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    tgs_item_if   item_ch ();
    tgs_result_if rsp_ch ();
    tgs_cfg_if    cfg_ch ();

    text_grid_with_scrollback_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (rsp_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted screen state
    int unsigned       n_cols, n_rows, hist_lim;
    logic [CELL_W-1:0] scr [NCOL*NROW];
    logic              scr_wrap [NROW];
    logic [CELL_W-1:0] hist [NHIST*NCOL];
    logic              hist_wrap [NHIST];
    int unsigned       hist_cnt, hist_old, view_off;

    // expected results in request order
    t_rsp        exp_fifo [EXP_DEPTH];
    int unsigned exp_wr = 0;
    int unsigned exp_rd = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    bit   stall_long = 0;

    task automatic screen_reset();
        n_cols = COLS_RESET; n_rows = ROWS_RESET; hist_lim = HLIM_RESET;
        foreach (scr[i]) scr[i] = '0;
        foreach (scr_wrap[i]) scr_wrap[i] = 1'b0;
        hist_cnt = 0; hist_old = 0; view_off = 0;
    endtask

    function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predict_cfg(t_cfg_reg idx, int unsigned v);
        case (idx)
            CFG_COLS:   n_cols = clampu(v & 8'hFF, 1, NCOL);
            CFG_ROWS:   n_rows = clampu(v & 7'h7F, 1, NROW);
            CFG_HLIMIT: hist_lim = clampu(v & 9'h1FF, 0, NHIST);
            default: ;
        endcase
    endfunction

    function automatic t_rsp predict_screen(t_req r);
        t_rsp o;
        int unsigned cx, cy, slot;
        int eff, idx;
        o = '{default: '0};
        cx = r.col >= n_cols ? n_cols - 1 : r.col;
        cy = r.row >= n_rows ? n_rows - 1 : r.row;
        case (r.kind)
            K_WRITE: scr[cy*n_cols+cx] = r.cval;
            K_READ:  o.cval = scr[cy*n_cols+cx];
            K_READ_VIS: begin
                eff = int'(r.row) - int'(view_off);
                if (eff < 0) begin
                    if (hist_cnt != 0) begin
                        idx = int'(hist_cnt) + eff;
                        if (idx < 0) idx = 0;
                        if (idx >= int'(hist_cnt)) idx = int'(hist_cnt) - 1;
                        o.cval = hist[((hist_old + idx) % NHIST)*NCOL + cx];
                    end
                end else begin
                    if (eff >= int'(n_rows)) eff = int'(n_rows) - 1;
                    o.cval = scr[eff*n_cols+cx];
                end
            end
            K_SCROLL_UP: begin
                if (hist_cnt >= NHIST) begin
                    slot = hist_old; hist_old = (hist_old + 1) % NHIST;
                end else begin
                    slot = (hist_old + hist_cnt) % NHIST; hist_cnt++;
                end
                for (int x = 0; x < n_cols; x++) hist[slot*NCOL+x] = scr[x];
                hist_wrap[slot] = scr_wrap[0];
                if (hist_cnt > hist_lim) begin
                    hist_old = (hist_old + 1) % NHIST; hist_cnt--;
                end
                if (view_off > 0) begin
                    view_off++;
                    if (view_off > hist_cnt) view_off = hist_cnt;
                end
                for (int y = 1; y < n_rows; y++) begin
                    for (int x = 0; x < n_cols; x++) scr[(y-1)*n_cols+x] = scr[y*n_cols+x];
                    scr_wrap[y-1] = scr_wrap[y];
                end
                for (int x = 0; x < n_cols; x++) scr[(n_rows-1)*n_cols+x] = '0;
                scr_wrap[n_rows-1] = 1'b0;
            end
            K_SCROLL_DOWN: begin
                for (int y = n_rows - 1; y >= 1; y--) begin
                    for (int x = 0; x < n_cols; x++) scr[y*n_cols+x] = scr[(y-1)*n_cols+x];
                    scr_wrap[y] = scr_wrap[y-1];
                end
                for (int x = 0; x < n_cols; x++) scr[x] = '0;
                scr_wrap[0] = 1'b0;
            end
            K_SET_FLAG: begin
                if (r.row < n_rows) scr_wrap[r.row] = r.wrap;
                o.wrap = r.row < n_rows ? scr_wrap[r.row] : 1'b0;
            end
            K_READ_FLAG: o.wrap = r.row < n_rows ? scr_wrap[r.row] : 1'b0;
            K_SET_OFFSET: view_off = r.offset > hist_cnt ? hist_cnt : r.offset;
            K_CLEAR: begin
                foreach (scr[i]) scr[i] = '0;
                foreach (scr_wrap[i]) scr_wrap[i] = 1'b0;
                hist_cnt = 0; hist_old = 0; view_off = 0;
            end
            default: ;
        endcase
        o.view_offset = OFF_W'(view_off);
        o.hist_count = CNT_OUT_W'(hist_cnt);
        return o;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic send_request(t_req r);
        int g;
        g = gap_len();
        if (g != 0) begin
            item_ch.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= r.kind;
        item_ch.col       <= r.col;
        item_ch.row       <= r.row;
        item_ch.cell_in   <= r.cval;
        item_ch.wrap_in   <= r.wrap;
        item_ch.offset_in <= r.offset;
        do @(posedge i_clk); while (!item_ch.ready);
        exp_fifo[exp_wr % EXP_DEPTH] = predict_screen(r);
        exp_wr++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        // short idle gap before a register write
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, int unsigned v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= v[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        predict_cfg(idx, v);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_req mk(t_kind k, int unsigned c, int unsigned rw,
                                logic [CELL_W-1:0] cl, int unsigned w, int unsigned of);
        t_req r;
        r.kind = k; r.col = COL_W'(c); r.row = ROW_W'(rw); r.cval = cl;
        r.wrap = 1'(w); r.offset = OFF_W'(of);
        return r;
    endfunction

    function automatic t_req rand_req(int unsigned wmix);
        t_req r;
        int unsigned p;
        r.col    = COL_W'($urandom_range(1) ? $urandom_range(n_cols) : $urandom_range(127));
        r.row    = ROW_W'($urandom_range(1) ? $urandom_range(n_rows) : $urandom_range(63));
        r.cval   = $urandom;
        r.wrap   = 1'($urandom_range(1));
        r.offset = OFF_W'($urandom_range(3) == 0 ? $urandom_range(511)
                                                 : $urandom_range(hist_cnt + 2));
        p = $urandom_range(99);
        if (p < wmix) r.kind = K_WRITE;
        else if (p < 40) r.kind = K_READ;
        else if (p < 58) r.kind = K_READ_VIS;
        else if (p < 70) r.kind = K_SCROLL_UP;
        else if (p < 76) r.kind = K_SCROLL_DOWN;
        else if (p < 82) r.kind = K_SET_FLAG;
        else if (p < 87) r.kind = K_READ_FLAG;
        else if (p < 95) r.kind = K_SET_OFFSET;
        else if (p < 96) r.kind = K_CLEAR;
        else r.kind = KIND_W'($urandom_range(15, 9));
        return r;
    endfunction

    // result checker with random receiver stalls
    always @(posedge i_clk) begin
        t_rsp e;
        if (rsp_ch.valid && rsp_ch.ready) begin
            if (exp_wr == exp_rd) begin
                $error("result with no request outstanding");
                errors++;
            end else begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (rsp_ch.cell_out !== e.cval) begin
                    $error("cell_out exp %h got %h", e.cval, rsp_ch.cell_out); errors++;
                end
                if (rsp_ch.wrap_out !== e.wrap) begin
                    $error("wrap_out exp %b got %b", e.wrap, rsp_ch.wrap_out); errors++;
                end
                if (rsp_ch.view_offset_out !== e.view_offset) begin
                    $error("view_offset_out exp %0d got %0d", e.view_offset,
                           rsp_ch.view_offset_out); errors++;
                end
                if (rsp_ch.history_count_out !== e.hist_count) begin
                    $error("history_count_out exp %0d got %0d", e.hist_count,
                           rsp_ch.history_count_out); errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int p;
        p = $urandom_range(99);
        if (!stall_long) rsp_ch.ready <= 1'b1;
        else rsp_ch.ready <= p >= 30 ? 1'b1 : (p < 2 ? 1'b0 : $urandom_range(1));
        if (p == 99) stall_long <= !stall_long;
    end

    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("** text_grid_with_scrollback_unit: FAILED **");
            $finish;
        end
    end

    task automatic test_cell_edges();
        send_request(mk(K_WRITE, 0, 0, 32'hFFFF_FFFF, 0, 0));
        send_request(mk(K_WRITE, 127, 63, 32'h8000_0001, 1, 511));
        send_request(mk(K_READ, 0, 0, 0, 0, 0));
        send_request(mk(K_READ, 79, 23, 0, 0, 0));
        send_request(mk(K_READ, 127, 63, 0, 0, 0));
        send_request(mk(K_SET_FLAG, 0, 0, 0, 1, 0));
        send_request(mk(K_SET_FLAG, 0, 63, 0, 1, 0));
        send_request(mk(K_READ_FLAG, 0, 0, 0, 0, 0));
        send_request(mk(K_READ_FLAG, 0, 40, 0, 0, 0));
        send_request(mk(t_kind'(4'd15), 5, 5, 32'h1234_5678, 1, 3));
    endtask

    task automatic test_scroll_history();
        send_request(mk(K_SET_OFFSET, 0, 0, 0, 0, 511));
        send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        send_request(mk(K_SET_OFFSET, 0, 0, 0, 0, 1));
        send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        send_request(mk(K_READ_VIS, 0, 0, 0, 0, 0));
        send_request(mk(K_READ_VIS, 127, 63, 0, 0, 0));
        send_request(mk(K_SET_OFFSET, 0, 0, 0, 0, 3));
        send_request(mk(K_READ_VIS, 3, 0, 0, 0, 0));
        send_request(mk(K_SCROLL_DOWN, 0, 0, 0, 0, 0));
        send_request(mk(K_READ, 0, 1, 0, 0, 0));
        send_request(mk(K_CLEAR, 0, 0, 0, 0, 0));
        send_request(mk(K_SET_OFFSET, 0, 0, 0, 0, 4));
        send_request(mk(K_READ_VIS, 0, 0, 0, 0, 0));
    endtask

    // history fill past a limit, then a lowered limit
    task automatic test_history_limit();
        write_reg(CFG_COLS, 4);
        write_reg(CFG_ROWS, 2);
        write_reg(CFG_HLIMIT, 300);
        for (int i = 0; i < 270; i++) begin
            if (i % 4 == 0)
                send_request(mk(K_WRITE, $urandom_range(3), $urandom_range(1), $urandom, 0, 0));
            send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        end
        send_request(mk(K_SET_OFFSET, 0, 0, 0, 0, 300));
        send_request(mk(K_READ_VIS, 2, 0, 0, 0, 0));
        write_reg(CFG_HLIMIT, 5);
        for (int i = 0; i < 4; i++) send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        write_reg(CFG_HLIMIT, 0);
        send_request(mk(K_CLEAR, 0, 0, 0, 0, 0));
        send_request(mk(K_SCROLL_UP, 0, 0, 0, 0, 0));
        send_request(mk(K_READ_VIS, 0, 0, 0, 0, 0));
    endtask

    task automatic run_random_phase(int unsigned c, int unsigned rw, int unsigned hl, int n);
        write_reg(CFG_COLS, c);
        write_reg(CFG_ROWS, rw);
        write_reg(CFG_HLIMIT, hl);
        // history slots hold only n_cols columns; clear so none reads unwritten
        send_request(mk(K_CLEAR, 0, 0, 0, 0, 0));
        for (int i = 0; i < n; i++) begin
            t_req r;
            r = rand_req(28);
            send_request(r);
        end
    endtask

    task automatic test_random();
        run_random_phase(1, 1, 3, 100);
        run_random_phase(8, 4, 20, 200);
        run_random_phase(0, 0, 511, 40);
        run_random_phase(16, 8, 256, 200);
        run_random_phase(3, 64, 2, 60);
        run_random_phase(128, 2, 10, 30);
        run_random_phase(255, 127, 7, 6);
        run_random_phase(5, 3, 30, 230);
    endtask

    initial begin
        item_ch.valid = 1'b0; item_ch.kind = '0; item_ch.col = '0; item_ch.row = '0;
        item_ch.cell_in = '0; item_ch.wrap_in = 1'b0; item_ch.offset_in = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = CFG_COLS; cfg_ch.data = '0;
        rsp_ch.ready = 1'b1;
        screen_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cell_edges();
        test_scroll_history();
        test_history_limit();
        test_random();
        drain();
        repeat (50) @(negedge i_clk);
        if (errors == 0 && exp_wr == exp_rd)
            $display("** text_grid_with_scrollback_unit: PASSED **");
        else
            $display("** text_grid_with_scrollback_unit: FAILED **");
        $finish;
    end
endmodule
